/* sv/cesd_pkg.sv */
// ---------------------------------------------------------------------------
// C escape sequence decoder package
// Decoder modes, result error codes, character codes and the hex digit
// decode shared by the decoder core.
// ---------------------------------------------------------------------------
package cesd_pkg;

	typedef enum logic [6:0] {
		MODE_COPY    = 7'b0000001,
		MODE_ESC     = 7'b0000010,
		MODE_OCT     = 7'b0000100,
		MODE_HEX     = 7'b0001000,
		MODE_U4      = 7'b0010000,
		MODE_U8      = 7'b0100000,
		MODE_SWALLOW = 7'b1000000
	} mode_t;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_TRAIL_BS  = 4'd1;
	localparam logic [3:0] ERR_OCT_RANGE = 4'd2;
	localparam logic [3:0] ERR_X_NODIG   = 4'd3;
	localparam logic [3:0] ERR_X_RANGE   = 4'd4;
	localparam logic [3:0] ERR_U4_SHORT  = 4'd5;
	localparam logic [3:0] ERR_U8_SHORT  = 4'd6;
	localparam logic [3:0] ERR_CP_RANGE  = 4'd7;
	localparam logic [3:0] ERR_SURROGATE = 4'd8;

	localparam int unsigned ACC_W = 21;

	localparam logic [ACC_W-1:0] BYTE_MAX   = 21'h0000FF;
	localparam logic [ACC_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [ACC_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [ACC_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [ACC_W-1:0] UTF8_LIM1  = 21'h000080;
	localparam logic [ACC_W-1:0] UTF8_LIM2  = 21'h000800;
	localparam logic [ACC_W-1:0] UTF8_LIM3  = 21'h010000;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QMARK  = 8'h3F;

	// Returns the digit value with a valid flag in the top bit.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= "0" && b <= "9") begin
			r = {1'b1, b[3:0]};
		end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

/* sv/c_escape_sequence_decoder_core.sv */
// ---------------------------------------------------------------------------
// C escape sequence decoder core
// Decodes a C-escaped byte string, one source byte per request, into the
// decoded bytes with UTF-8 output for universal character names.
// ---------------------------------------------------------------------------
// Each accepted source byte is decoded in the cycle it is accepted and its
// zero to four results are loaded into an output register bank that drains
// one result per cycle while the sink is ready. A byte that yields at most
// one result is taken every cycle while the sink is ready; for a byte that
// yields more results the input side waits while the bank drains, so a \U
// escape that ends in a four byte UTF-8 sequence waits until its last byte is
// being taken. The source stays ready while the last pending result is taken.
module c_escape_sequence_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
	output logic        m_tlast,   // run_last
	output logic        m_tuser    // string_done
);

	localparam int unsigned AW = cesd_pkg::ACC_W;

	cesd_pkg::mode_t mode_q, mode_n;
	logic [AW-1:0]   acc_q, acc_n, acc_t;
	logic            ovf_q, ovf_n;
	logic [3:0]      cnt_q, cnt_n;

	logic [7:0]      res_byte_q [4];
	logic [3:0]      res_err_q  [4];
	logic [2:0]      left_q;
	logic [1:0]      rd_q;
	logic            done_q;

	logic [7:0]      rb [4];
	logic [3:0]      re [4];
	logic [2:0]      np;
	logic            failed;
	logic            do_copy;
	logic            simple_ok;
	logic [7:0]      simple_val;
	logic [4:0]      hv;
	logic [3:0]      need;
	logic [3:0]      short_code;
	logic [7:0]      b;
	logic            eos;
	logic            in_acc;
	logic            out_acc;

	assign b       = s_tdata;
	assign eos     = s_tlast;
	assign hv      = cesd_pkg::hex_val(s_tdata);
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	assign s_tready = (left_q == 3'd0) || (left_q == 3'd1 && m_tready);
	assign m_tvalid = left_q != 3'd0;
	assign m_tlast  = left_q == 3'd1;
	assign m_tuser  = m_tlast && done_q;
	assign m_tdata  = {4'd0, res_err_q[rd_q], res_byte_q[rd_q]};

	always_comb begin
		simple_ok  = 1'b1;
		simple_val = b;
		case (b) inside
			"a": simple_val = 8'h07;
			"b": simple_val = 8'h08;
			"f": simple_val = 8'h0C;
			"n": simple_val = 8'h0A;
			"r": simple_val = 8'h0D;
			"t": simple_val = 8'h09;
			"v": simple_val = 8'h0B;
			cesd_pkg::CH_BSLASH, cesd_pkg::CH_SQUOTE,
			cesd_pkg::CH_DQUOTE, cesd_pkg::CH_QMARK: simple_val = b;
			default: simple_ok = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rb[i] = 8'd0;
			re[i] = cesd_pkg::ERR_NONE;
		end
		np      = 3'd0;
		failed  = 1'b0;
		do_copy = 1'b0;
		mode_n  = mode_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		cnt_n   = cnt_q;
		acc_t   = '0;
		need    = (mode_q == cesd_pkg::MODE_U8) ? 4'd8 : 4'd4;
		short_code = (mode_q == cesd_pkg::MODE_U8) ? cesd_pkg::ERR_U8_SHORT
		                                          : cesd_pkg::ERR_U4_SHORT;

		unique case (mode_q) inside
			cesd_pkg::MODE_ESC: begin
				mode_n = cesd_pkg::MODE_COPY;
				acc_n  = '0;
				ovf_n  = 1'b0;
				cnt_n  = 4'd0;
				if (simple_ok) begin
					rb[0] = simple_val;
					np    = 3'd1;
				end else if (b >= "0" && b <= "7") begin
					acc_n = {{(AW-3){1'b0}}, b[2:0]};
					cnt_n = 4'd1;
					if (eos) begin
						rb[0] = {5'd0, b[2:0]};
						np    = 3'd1;
					end else begin
						mode_n = cesd_pkg::MODE_OCT;
					end
				end else if (b == "x") begin
					if (eos) begin
						re[0]  = cesd_pkg::ERR_X_NODIG;
						np     = 3'd1;
						failed = 1'b1;
					end else begin
						mode_n = cesd_pkg::MODE_HEX;
					end
				end else if (b == "u" || b == "U") begin
					if (eos) begin
						re[0]  = (b == "u") ? cesd_pkg::ERR_U4_SHORT : cesd_pkg::ERR_U8_SHORT;
						np     = 3'd1;
						failed = 1'b1;
					end else begin
						mode_n = (b == "u") ? cesd_pkg::MODE_U4 : cesd_pkg::MODE_U8;
					end
				end else begin
					rb[0] = cesd_pkg::CH_BSLASH;
					rb[1] = b;
					np    = 3'd2;
				end
			end
			cesd_pkg::MODE_OCT: begin
				if (b >= "0" && b <= "7") begin
					acc_t = {acc_q[AW-4:0], b[2:0]};
					acc_n = acc_t;
					cnt_n = cnt_q + 4'd1;
					if (cnt_n >= 4'd3) begin
						if (acc_t > cesd_pkg::BYTE_MAX) begin
							re[0]  = cesd_pkg::ERR_OCT_RANGE;
							failed = 1'b1;
						end else begin
							rb[0] = acc_t[7:0];
						end
						np     = 3'd1;
						mode_n = cesd_pkg::MODE_COPY;
						acc_n  = '0;
						ovf_n  = 1'b0;
						cnt_n  = 4'd0;
					end else if (eos) begin
						rb[0] = acc_t[7:0];
						np    = 3'd1;
					end
				end else begin
					rb[0]   = acc_q[7:0];
					np      = 3'd1;
					do_copy = 1'b1;
				end
			end
			cesd_pkg::MODE_HEX: begin
				if (hv[4]) begin
					acc_t = {acc_q[AW-5:0], hv[3:0]};
					acc_n = acc_t;
					cnt_n = 4'd1;
					if (acc_t > cesd_pkg::BYTE_MAX) begin
						re[0]  = cesd_pkg::ERR_X_RANGE;
						np     = 3'd1;
						failed = 1'b1;
					end else if (eos) begin
						rb[0] = acc_t[7:0];
						np    = 3'd1;
					end
				end else if (cnt_q == 4'd0) begin
					re[0]  = cesd_pkg::ERR_X_NODIG;
					np     = 3'd1;
					failed = 1'b1;
				end else begin
					rb[0]   = acc_q[7:0];
					np      = 3'd1;
					do_copy = 1'b1;
				end
			end
			cesd_pkg::MODE_U4, cesd_pkg::MODE_U8: begin
				if (!hv[4]) begin
					re[0]  = short_code;
					np     = 3'd1;
					failed = 1'b1;
				end else begin
					if (acc_q[AW-1:AW-4] != 4'd0) begin
						ovf_n = 1'b1;
					end
					acc_t = {acc_q[AW-5:0], hv[3:0]};
					acc_n = acc_t;
					cnt_n = cnt_q + 4'd1;
					if (cnt_n >= need) begin
						if (ovf_n || acc_t > cesd_pkg::CP_MAX) begin
							re[0]  = cesd_pkg::ERR_CP_RANGE;
							np     = 3'd1;
							failed = 1'b1;
						end else if (acc_t >= cesd_pkg::SURR_LO && acc_t <= cesd_pkg::SURR_HI) begin
							re[0]  = cesd_pkg::ERR_SURROGATE;
							np     = 3'd1;
							failed = 1'b1;
						end else if (acc_t < cesd_pkg::UTF8_LIM1) begin
							rb[0] = acc_t[7:0];
							np    = 3'd1;
						end else if (acc_t < cesd_pkg::UTF8_LIM2) begin
							rb[0] = {3'b110, acc_t[10:6]};
							rb[1] = {2'b10, acc_t[5:0]};
							np    = 3'd2;
						end else if (acc_t < cesd_pkg::UTF8_LIM3) begin
							rb[0] = {4'b1110, acc_t[15:12]};
							rb[1] = {2'b10, acc_t[11:6]};
							rb[2] = {2'b10, acc_t[5:0]};
							np    = 3'd3;
						end else begin
							rb[0] = {5'b11110, acc_t[20:18]};
							rb[1] = {2'b10, acc_t[17:12]};
							rb[2] = {2'b10, acc_t[11:6]};
							rb[3] = {2'b10, acc_t[5:0]};
							np    = 3'd4;
						end
						mode_n = cesd_pkg::MODE_COPY;
						acc_n  = '0;
						ovf_n  = 1'b0;
						cnt_n  = 4'd0;
					end else if (eos) begin
						re[0]  = short_code;
						np     = 3'd1;
						failed = 1'b1;
					end
				end
			end
			cesd_pkg::MODE_SWALLOW: begin
			end
			default: begin
				do_copy = 1'b1;
			end
		endcase

		if (do_copy) begin
			mode_n = cesd_pkg::MODE_COPY;
			acc_n  = '0;
			ovf_n  = 1'b0;
			cnt_n  = 4'd0;
			if (b == cesd_pkg::CH_BSLASH) begin
				if (eos) begin
					rb[np[1:0]] = 8'd0;
					re[np[1:0]] = cesd_pkg::ERR_TRAIL_BS;
					np          = np + 3'd1;
					failed      = 1'b1;
				end else begin
					mode_n = cesd_pkg::MODE_ESC;
				end
			end else begin
				rb[np[1:0]] = b;
				re[np[1:0]] = cesd_pkg::ERR_NONE;
				np          = np + 3'd1;
			end
		end

		if (eos || failed) begin
			mode_n = eos ? cesd_pkg::MODE_COPY : cesd_pkg::MODE_SWALLOW;
			acc_n  = '0;
			ovf_n  = 1'b0;
			cnt_n  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cesd_pkg::MODE_COPY;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= 4'd0;
			left_q <= 3'd0;
			rd_q   <= 2'd0;
			done_q <= 1'b0;
		end else if (in_acc) begin
			mode_q <= mode_n;
			acc_q  <= acc_n;
			ovf_q  <= ovf_n;
			cnt_q  <= cnt_n;
			left_q <= np;
			rd_q   <= 2'd0;
			done_q <= eos || failed;
		end else if (out_acc) begin
			left_q <= left_q - 3'd1;
			rd_q   <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 4; i++) begin
				res_byte_q[i] <= rb[i];
				res_err_q[i]  <= re[i];
			end
		end
	end

`ifndef ASSERT_OFF
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= 3'd4)
		else $error("result count above four");

	a_swallow_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == cesd_pkg::MODE_SWALLOW) |-> (acc_q == '0 && cnt_q == 4'd0 && !ovf_q))
		else $error("accumulator not cleared while swallowing");

	a_hex_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == cesd_pkg::MODE_HEX) |-> (acc_q <= cesd_pkg::BYTE_MAX))
		else $error("hex accumulator above byte range");

	a_drain_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || $past(s_tvalid && s_tready)))
		else $error("result appeared without a new request");
`endif

endmodule
